@@ hw/rtl/srje_pkg.sv @@
// Shared types, constants and compare function for the sorted ring eliminator.
// Used by srje_cell and sorted_ring_josephus_eliminator; no dependencies.
`default_nettype none

package srje_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int STEP_W   = 8;
  localparam int STAT_W   = 3;

  typedef logic signed [VAL_W-1:0] value_t;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_LEFT   = 2'd2,
    OP_ROTATE = 2'd3
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_ELIM = 2'b10
  } state_t;

  typedef struct packed {
    cell_op_t op;
    logic     descending;
    value_t   new_value;
    value_t   head_value;
  } cell_ctrl_t;

  typedef struct packed {
    logic   valid;
    logic   valid_prev;
    logic   gt_prev;
    logic   tail;
    value_t prev_value;
    value_t next_value;
  } cell_link_t;

  function automatic logic ranks_after(input value_t a, input value_t x, input logic desc);
    ranks_after = desc ? (a < x) : (a > x);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/srje_cell.sv @@
// One storage cell of the sorted ring: holds a value, compares it with the
// incoming value and shifts, inserts or rotates with its neighbors. Uses srje_pkg.
`default_nettype none

module srje_cell (
  input  wire                      clk,
  input  srje_pkg::cell_ctrl_t     ctrl,
  input  srje_pkg::cell_link_t     link,
  output srje_pkg::value_t         value,
  output logic                     gt,
  output logic                     eq
);
  import srje_pkg::*;

  value_t value_next;

  assign gt = link.valid && ranks_after(value, ctrl.new_value, ctrl.descending);
  assign eq = link.valid && (value == ctrl.new_value);

  always_comb begin
    value_next = value;
    case (ctrl.op)
      OP_INSERT: begin
        if (link.gt_prev) begin
          value_next = link.prev_value;
        end else if (gt || (!link.valid && link.valid_prev)) begin
          value_next = ctrl.new_value;
        end
      end
      OP_LEFT: begin
        value_next = link.next_value;
      end
      OP_ROTATE: begin
        value_next = link.tail ? ctrl.head_value : link.next_value;
      end
      default: begin
        value_next = value;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

`default_nettype wire

@@ hw/rtl/sorted_ring_josephus_eliminator.sv @@
// Top level of the sorted ring with Josephus elimination: control sequencer,
// output register and a chain of srje_cell. Uses srje_pkg and srje_cell.
//
// On an insert beat every cell compares against the new value at once and the
// chain shifts by one place. An eliminate beat on n stored values with count k
// (0 read as 1) empties the store: per removal the chain rotates the ring by
// one place per cycle, k-1 times, then drops the head into the output register.
// An empty store answers with an empty status. No new beat is taken while an
// elimination runs or while the output register holds an untaken beat.
`default_nettype none

module sorted_ring_josephus_eliminator (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire                              cfg_wdata,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire                              func,
  input  wire signed [srje_pkg::VAL_W-1:0] value,
  input  wire [srje_pkg::STEP_W-1:0]       step,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [srje_pkg::STAT_W-1:0]      status,
  output logic signed [srje_pkg::VAL_W-1:0] removed_value,
  output logic                             last
);
  import srje_pkg::*;

  state_t              state;
  logic                order_descending;
  logic [CNT_W-1:0]    entry_count;
  logic [STEP_W-1:0]   count_position;
  logic [STEP_W-1:0]   elim_skip;
  logic [STEP_W-1:0]   step_m1;
  cell_ctrl_t          ctrl;
  cell_link_t          link   [CAPACITY];
  value_t              cell_v [CAPACITY];
  logic [CAPACITY-1:0] cell_gt;
  logic [CAPACITY-1:0] cell_eq;
  logic                can_emit;
  logic                accept;
  logic                load_out;
  logic                dup;
  logic                full;

  assign can_emit = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !can_emit;
  assign accept   = in_valid && !in_stall;
  assign dup      = |cell_eq;
  assign full     = (entry_count == CNT_W'(CAPACITY));
  assign step_m1  = (step == '0) ? '0 : step - STEP_W'(1);
  assign load_out = (state == S_IDLE) ? (accept && (!func || (entry_count == '0)))
                  : ((state == S_ELIM) && (count_position == '0) && can_emit);

  always_comb begin
    ctrl.op         = OP_HOLD;
    ctrl.descending = order_descending;
    ctrl.new_value  = value;
    ctrl.head_value = cell_v[0];
    case (state)
      S_IDLE: begin
        if (accept && !func && !dup && !full) begin
          ctrl.op = OP_INSERT;
        end
      end
      S_ELIM: begin
        if (count_position != '0) begin
          ctrl.op = OP_ROTATE;
        end else if (can_emit) begin
          ctrl.op = OP_LEFT;
        end
      end
      default: begin
        ctrl.op = OP_HOLD;
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_comb begin
      link[i].valid      = CNT_W'(i) < entry_count;
      link[i].tail       = entry_count == CNT_W'(i + 1);
      link[i].valid_prev = (i == 0) ? 1'b1 : (CNT_W'(i) <= entry_count);
      link[i].gt_prev    = (i == 0) ? 1'b0 : cell_gt[(i == 0) ? 0 : i - 1];
      link[i].prev_value = (i == 0) ? '0 : cell_v[(i == 0) ? 0 : i - 1];
      link[i].next_value = (i == CAPACITY - 1) ? '0
                         : cell_v[(i == CAPACITY - 1) ? i : i + 1];
    end

    srje_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .link  (link[i]),
      .value (cell_v[i]),
      .gt    (cell_gt[i]),
      .eq    (cell_eq[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      order_descending <= 1'b0;
      entry_count      <= '0;
      count_position   <= '0;
      elim_skip        <= '0;
      out_valid        <= 1'b0;
      status           <= ST_INSERTED;
      removed_value    <= '0;
      last             <= 1'b0;
    end else begin
      if (cfg_we) begin
        order_descending <= cfg_wdata;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (!func) begin
              removed_value <= '0;
              last          <= 1'b1;
              if (dup) begin
                status <= ST_DUPLICATE;
              end else if (full) begin
                status <= ST_FULL;
              end else begin
                status      <= ST_INSERTED;
                entry_count <= entry_count + CNT_W'(1);
              end
            end else if (entry_count == '0) begin
              status        <= ST_EMPTY;
              removed_value <= '0;
              last          <= 1'b1;
            end else begin
              count_position <= step_m1;
              elim_skip      <= step_m1;
              state          <= S_ELIM;
            end
          end
        end
        S_ELIM: begin
          if (count_position != '0) begin
            count_position <= count_position - STEP_W'(1);
          end else if (can_emit) begin
            status        <= ST_REMOVED;
            removed_value <= cell_v[0];
            last          <= (entry_count == CNT_W'(1));
            entry_count   <= entry_count - CNT_W'(1);
            if (entry_count == CNT_W'(1)) begin
              count_position <= '0;
              state          <= S_IDLE;
            end else begin
              count_position <= elim_skip;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking bench for sorted_ring_josephus_eliminator: queued beats, a
// clocked driver and monitor, and a ring predictor of inserts and eliminations.
// Depends on srje_pkg and the RTL top level; nothing else.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import srje_pkg::*;

  typedef struct {
    logic              func;
    value_t            value;
    logic [STEP_W-1:0] step;
  } beat_t;

  typedef struct {
    status_t status;
    value_t  removed;
    logic    last;
  } ring_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic                     cfg_wdata = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     func = 1'b0;
  logic signed [VAL_W-1:0]  value = '0;
  logic [STEP_W-1:0]        step = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [STAT_W-1:0]        status;
  logic signed [VAL_W-1:0]  removed_value;
  logic                     last;

  beat_t        stim_beats[$];
  ring_result_t predicted_results[$];

  value_t ring_vals[CAPACITY];
  int     ring_fill = 0;
  logic   ring_desc = 1'b0;

  int     errors = 0;
  bit     quiet = 1'b0;
  int     gap_left = 0;
  int     stall_left = 0;

  sorted_ring_josephus_eliminator dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .value         (value),
    .step          (step),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .removed_value (removed_value),
    .last          (last)
  );

  always #5 clk = ~clk;

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit ring_ranks_after(value_t a, value_t x);
    return ring_desc ? (a < x) : (a > x);
  endfunction

  function automatic void push_result(status_t s, value_t v, logic l);
    ring_result_t r;
    r.status  = s;
    r.removed = v;
    r.last    = l;
    predicted_results.push_back(r);
  endfunction

  function automatic void ring_apply_beat(logic f, value_t x, logic [STEP_W-1:0] k_in);
    int at, n, pos, k;
    value_t gone;
    if (f == 1'b0) begin
      for (int i = 0; i < ring_fill; i++) begin
        if (ring_vals[i] == x) begin
          push_result(ST_DUPLICATE, '0, 1'b1);
          return;
        end
      end
      if (ring_fill >= CAPACITY) begin
        push_result(ST_FULL, '0, 1'b1);
        return;
      end
      at = ring_fill;
      for (int i = 0; i < ring_fill; i++) begin
        if (ring_ranks_after(ring_vals[i], x)) begin
          at = i;
          break;
        end
      end
      for (int i = ring_fill; i > at; i--) ring_vals[i] = ring_vals[i-1];
      ring_vals[at] = x;
      ring_fill++;
      push_result(ST_INSERTED, '0, 1'b1);
      return;
    end
    k = (k_in == 0) ? 1 : int'(k_in);
    n = ring_fill;
    if (n == 0) begin
      push_result(ST_EMPTY, '0, 1'b1);
      return;
    end
    pos = 0;
    while (n > 0) begin
      pos = (pos + k - 1) % n;
      gone = ring_vals[pos];
      for (int i = pos; i + 1 < n; i++) ring_vals[i] = ring_vals[i+1];
      n--;
      if (pos >= n) pos = 0;
      push_result(ST_REMOVED, gone, n == 0);
    end
    ring_fill = 0;
  endfunction

  // driver: hold a stalled beat, predict on acceptance, then gap or load next
  always @(posedge clk) begin
    beat_t b;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) ring_apply_beat(func, value, step);
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (stim_beats.size() > 0) begin
        b = stim_beats.pop_front();
        in_valid <= 1'b1;
        func     <= b.func;
        value    <= b.value;
        step     <= b.step;
        gap_left = pick_idle();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: check accepted beats against the oldest prediction
  always @(posedge clk) begin
    ring_result_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          $error("unexpected result: status %0d removed_value %0d last %0d",
                 status, removed_value, last);
          errors++;
        end else begin
          e = predicted_results.pop_front();
          if (status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status);
            errors++;
          end
          if (removed_value !== e.removed) begin
            $error("removed_value: expected %0d, got %0d", e.removed, removed_value);
            errors++;
          end
          if (last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, last);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_idle();
      end
    end
  end

  function automatic void push_beat(logic f, value_t x, logic [STEP_W-1:0] k);
    beat_t b;
    b.func  = f;
    b.value = x;
    b.step  = k;
    stim_beats.push_back(b);
  endfunction

  function automatic value_t rand_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return value_t'($urandom_range(0, 20)) - 10;
    if (r == 6) return 32'sh7fffffff - value_t'($urandom_range(0, 3));
    if (r == 7) return 32'sh80000000 + value_t'($urandom_range(0, 3));
    return value_t'($urandom);
  endfunction

  function automatic logic [STEP_W-1:0] rand_step();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return STEP_W'($urandom_range(200, 255));
    if (r < 4) return '0;
    if (r < 12) return STEP_W'($urandom_range(1, 4));
    return STEP_W'($urandom_range(5, 20));
  endfunction

  task automatic wait_idle();
    @(negedge clk);
    while (stim_beats.size() != 0 || in_valid || predicted_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_order(logic desc);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= desc;
    @(posedge clk);
    cfg_we    <= 1'b0;
    ring_desc = desc;
    @(negedge clk);
  endtask

  task automatic queue_random_phase(int target);
    int added, n_ins, r;
    added = 0;
    while (added < target) begin
      if ($urandom_range(0, 9) == 0) begin
        push_beat(1'($urandom_range(0, 1)), rand_value(), STEP_W'($urandom_range(0, 255)));
        added++;
      end else begin
        r = $urandom_range(0, 19);
        if (r < 3) n_ins = $urandom_range(17, 20);
        else if (r < 8) n_ins = $urandom_range(8, 16);
        else n_ins = $urandom_range(1, 7);
        repeat (n_ins) push_beat(1'b0, rand_value(), STEP_W'($urandom_range(0, 255)));
        push_beat(1'b1, rand_value(), rand_step());
        added += n_ins + 1;
        if ($urandom_range(0, 7) == 0) begin
          push_beat(1'b1, rand_value(), rand_step());
          added++;
        end
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    write_order(1'b0);

    push_beat(1'b1, '0, 8'd0);
    push_beat(1'b0, 32'sh7fffffff, 8'd0);
    push_beat(1'b0, 32'sh80000000, 8'd0);
    push_beat(1'b0, 32'sd0, 8'd0);
    push_beat(1'b0, -32'sd1, 8'd0);
    push_beat(1'b0, 32'sh80000000, 8'd0);
    push_beat(1'b1, '0, 8'd0);
    for (int i = 0; i < CAPACITY; i++)
      push_beat(1'b0, value_t'(((i * 5) % 16) * 7 - 50), 8'd0);
    push_beat(1'b0, -32'sd50, 8'd0);
    push_beat(1'b0, 32'sd1000, 8'd0);
    push_beat(1'b1, '0, 8'd255);

    for (int p = 0; p < 6; p++) begin
      write_order((p % 3) != 1);
      quiet = ($urandom_range(0, 3) == 0);
      queue_random_phase(27);
    end

    wait_idle();
    repeat (60) @(negedge clk);
    if (errors == 0 && predicted_results.size() == 0) begin
      $display("sorted_ring_josephus_eliminator regression: pass");
    end else begin
      $display("sorted_ring_josephus_eliminator regression: fail");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("sorted_ring_josephus_eliminator regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
